@@ rtl/owtr_pkg.sv @@
// Shared types and constants of the one-wire temperature reader.
package owtr_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned TEMP_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PRE_RESET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_RELEASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SLOT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERT_WAIT  = 3'd5;

    localparam logic [CFG_W-1:0] RST_PRE_RESET     = 16'd8;
    localparam logic [CFG_W-1:0] RST_RESET_LOW     = 16'd65;
    localparam logic [CFG_W-1:0] RST_RESET_RELEASE = 16'd20;
    localparam logic [CFG_W-1:0] RST_WRITE_SLOT    = 16'd5;
    localparam logic [CFG_W-1:0] RST_READ_SLOT     = 16'd4;
    localparam logic [CFG_W-1:0] RST_CONVERT_WAIT  = 16'd10;

    typedef struct packed {
        logic [CFG_W-1:0] pre_reset;
        logic [CFG_W-1:0] reset_low;
        logic [CFG_W-1:0] reset_release;
        logic [CFG_W-1:0] write_slot;
        logic [CFG_W-1:0] read_slot;
        logic [CFG_W-1:0] convert_wait;
    } t_cfg;

    typedef struct packed {
        logic              bus_release;
        logic              busy;
        logic              done;
        logic [TEMP_W-1:0] temperature;
    } t_res;

endpackage

@@ rtl/owtr_cfg.sv @@
// Configuration register bank of the one-wire temperature reader.
module owtr_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [owtr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [owtr_pkg::CFG_W-1:0]       i_cfg_data,
    output owtr_pkg::t_cfg                   o_cfg
);

    owtr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pre_reset     <= owtr_pkg::RST_PRE_RESET;
            r_cfg.reset_low     <= owtr_pkg::RST_RESET_LOW;
            r_cfg.reset_release <= owtr_pkg::RST_RESET_RELEASE;
            r_cfg.write_slot    <= owtr_pkg::RST_WRITE_SLOT;
            r_cfg.read_slot     <= owtr_pkg::RST_READ_SLOT;
            r_cfg.convert_wait  <= owtr_pkg::RST_CONVERT_WAIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                owtr_pkg::CFG_PRE_RESET:     r_cfg.pre_reset     <= i_cfg_data;
                owtr_pkg::CFG_RESET_LOW:     r_cfg.reset_low     <= i_cfg_data;
                owtr_pkg::CFG_RESET_RELEASE: r_cfg.reset_release <= i_cfg_data;
                owtr_pkg::CFG_WRITE_SLOT:    r_cfg.write_slot    <= i_cfg_data;
                owtr_pkg::CFG_READ_SLOT:     r_cfg.read_slot     <= i_cfg_data;
                owtr_pkg::CFG_CONVERT_WAIT:  r_cfg.convert_wait  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/owtr_core.sv @@
// Bus sequencer: one tick of the reset / write / read slot machine per request.
module owtr_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  logic            i_action,
    input  logic            i_bus_level,
    input  owtr_pkg::t_cfg  i_cfg,
    output owtr_pkg::t_res  o_res
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PRE,
        PH_RLOW,
        PH_RREL,
        PH_WLOW,
        PH_WDATA,
        PH_WREC,
        PH_WAIT,
        PH_RDLOW,
        PH_RDREL,
        PH_RDSAMP,
        PH_RDREC
    } t_phase;

    typedef struct packed {
        t_phase                         phase;
        logic [owtr_pkg::CFG_W-1:0]     tick;
        logic [7:0]                     shift;
        logic [3:0]                     bits;
        logic [3:0]                     step;
        logic [7:0]                     low;
        logic [owtr_pkg::TEMP_W-1:0]    result;
    } t_seq;

    localparam logic [3:0] STEP_RESET1       = 4'd0;
    localparam logic [3:0] STEP_SKIP1        = 4'd1;
    localparam logic [3:0] STEP_CONVERT      = 4'd2;
    localparam logic [3:0] STEP_CONV_WAIT    = 4'd3;
    localparam logic [3:0] STEP_RESET2       = 4'd4;
    localparam logic [3:0] STEP_SKIP2        = 4'd5;
    localparam logic [3:0] STEP_READ_SCRATCH = 4'd6;
    localparam logic [3:0] STEP_LOW_BYTE     = 4'd7;
    localparam logic [3:0] STEP_HIGH_BYTE    = 4'd8;
    localparam logic [3:0] BITS_PER_BYTE     = 4'd8;
    localparam logic [7:0] CMD_SKIP_ROM      = 8'hCC;
    localparam logic [7:0] CMD_CONVERT       = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH  = 8'hBE;
    localparam int unsigned MAX_SKIP         = 5;

    function automatic logic [owtr_pkg::CFG_W-1:0] f_len(t_phase p, owtr_pkg::t_cfg c);
        unique case (p)
            PH_IDLE:  f_len = '0;
            PH_PRE:   f_len = c.pre_reset;
            PH_RLOW:  f_len = c.reset_low;
            PH_RREL:  f_len = c.reset_release;
            PH_WDATA: f_len = c.write_slot;
            PH_RDREC: f_len = c.read_slot;
            PH_WAIT:  f_len = c.convert_wait;
            default:  f_len = 16'd1;
        endcase
    endfunction

    function automatic t_seq f_dispatch(t_seq s_in);
        t_seq s;
        s = s_in;
        s.bits = '0;
        unique case (s.step)
            STEP_RESET1, STEP_RESET2: s.phase = PH_PRE;
            STEP_SKIP1, STEP_SKIP2: begin
                s.shift = CMD_SKIP_ROM;
                s.phase = PH_WLOW;
            end
            STEP_CONVERT: begin
                s.shift = CMD_CONVERT;
                s.phase = PH_WLOW;
            end
            STEP_READ_SCRATCH: begin
                s.shift = CMD_READ_SCRATCH;
                s.phase = PH_WLOW;
            end
            STEP_CONV_WAIT: s.phase = PH_WAIT;
            STEP_LOW_BYTE, STEP_HIGH_BYTE: begin
                s.shift = '0;
                s.phase = PH_RDLOW;
            end
            default: begin
                s.step  = STEP_RESET1;
                s.phase = PH_IDLE;
            end
        endcase
        return s;
    endfunction

    function automatic t_seq f_next(t_seq s_in);
        t_seq s;
        s = s_in;
        unique case (s.phase)
            PH_PRE:   s.phase = PH_RLOW;
            PH_RLOW:  s.phase = PH_RREL;
            PH_RREL: begin
                s.step = s.step + 4'd1;
                s = f_dispatch(s);
            end
            PH_WLOW:  s.phase = PH_WDATA;
            PH_WDATA: s.phase = PH_WREC;
            PH_WREC: begin
                s.shift = s.shift >> 1;
                s.bits  = s.bits + 4'd1;
                if (s.bits < BITS_PER_BYTE) begin
                    s.phase = PH_WLOW;
                end else begin
                    s.step = s.step + 4'd1;
                    s = f_dispatch(s);
                end
            end
            PH_WAIT: begin
                s.step = STEP_RESET2;
                s = f_dispatch(s);
            end
            PH_RDLOW:  s.phase = PH_RDREL;
            PH_RDREL:  s.phase = PH_RDSAMP;
            PH_RDSAMP: s.phase = PH_RDREC;
            PH_RDREC: begin
                s.bits = s.bits + 4'd1;
                if (s.bits < BITS_PER_BYTE) begin
                    s.phase = PH_RDLOW;
                end else if (s.step == STEP_LOW_BYTE) begin
                    s.low  = s.shift;
                    s.step = STEP_HIGH_BYTE;
                    s = f_dispatch(s);
                end else begin
                    s.result = {s.shift[3:0], s.low[7:4]};
                    s.step   = STEP_RESET1;
                    s.bits   = '0;
                    s.phase  = PH_IDLE;
                end
            end
            default: s.phase = PH_IDLE;
        endcase
        return s;
    endfunction

    function automatic t_seq f_enter(t_seq s_in, owtr_pkg::t_cfg c);
        t_seq s;
        s = s_in;
        for (int k = 0; k < MAX_SKIP; k++) begin
            if (s.phase != PH_IDLE && f_len(s.phase, c) == '0) begin
                s = f_next(s);
            end
        end
        s.tick = f_len(s.phase, c);
        return s;
    endfunction

    t_seq           r_seq;
    t_seq           n_seq;
    owtr_pkg::t_res n_res;

    always_comb begin
        n_seq = r_seq;
        n_res.bus_release = 1'b1;
        n_res.busy        = 1'b0;
        n_res.done        = 1'b0;
        if (i_action) begin
            n_seq.step  = STEP_RESET1;
            n_seq.bits  = '0;
            n_seq.shift = '0;
            n_seq = f_enter(f_dispatch(n_seq), i_cfg);
        end
        if (n_seq.phase != PH_IDLE) begin
            n_res.busy = 1'b1;
            if (n_seq.phase == PH_RLOW || n_seq.phase == PH_WLOW ||
                n_seq.phase == PH_RDLOW) begin
                n_res.bus_release = 1'b0;
            end else if (n_seq.phase == PH_WDATA) begin
                n_res.bus_release = n_seq.shift[0];
            end
            if (n_seq.phase == PH_RDSAMP) begin
                n_seq.shift = {i_bus_level, n_seq.shift[7:1]};
            end
            if (n_seq.tick != '0) begin
                n_seq.tick = n_seq.tick - 16'd1;
            end
            if (n_seq.tick == '0) begin
                n_seq = f_enter(f_next(n_seq), i_cfg);
                n_res.done = (n_seq.phase == PH_IDLE);
            end
        end
        n_res.temperature = n_seq.result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '{phase: PH_IDLE, default: '0};
        end else if (i_fire) begin
            r_seq <= n_seq;
        end
    end

    assign o_res = n_res;

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq.phase == PH_IDLE |-> (r_seq.step == '0 && r_seq.tick == '0))
        else $error("idle sequencer holds a stale step or tick count");

    a_active_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq.phase != PH_IDLE |-> r_seq.tick != '0)
        else $error("active phase with an expired tick count");

    a_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq.bits < BITS_PER_BYTE)
        else $error("bit counter ran past a byte");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && n_res.done) |=> r_seq.phase == PH_IDLE)
        else $error("done reported while the sequencer stays active");

endmodule

@@ rtl/one_wire_temperature_reader.sv @@
// One-wire temperature reader top level: request registers, sequencer, result register.
// A request accepted into the request registers waits there until the result register is
// free or being taken, and its result is then registered into the result register.
// Throughput: one request per cycle while the result side takes results each cycle.
// Reset (i_rst_n low, synchronous) empties both registers, idles the sequencer
// and loads the default slot timing into the configuration registers.
module one_wire_temperature_reader (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_action,
    input  logic                             i_bus_level,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_bus_release,
    output logic                             o_busy_res,
    output logic                             o_done_res,
    output logic [owtr_pkg::TEMP_W-1:0]      o_temperature,
    input  logic                             i_cfg_we,
    input  logic [owtr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [owtr_pkg::CFG_W-1:0]       i_cfg_data
);

    owtr_pkg::t_cfg w_cfg;
    owtr_pkg::t_res w_res;
    owtr_pkg::t_res r_res;

    logic r_in_vld;
    logic r_action;
    logic r_bus_level;
    logic r_out_vld;
    logic w_fire;
    logic w_accept;

    assign w_fire     = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    owtr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    owtr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_action    (r_action),
        .i_bus_level (r_bus_level),
        .i_cfg       (w_cfg),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action    <= i_action;
            r_bus_level <= i_bus_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_bus_release = r_res.bus_release;
    assign o_busy_res    = r_res.busy;
    assign o_done_res    = r_res.done;
    assign o_temperature = r_res.temperature;

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (!r_res.done || r_res.busy))
        else $error("done result without busy");

    a_fire_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_vld)
        else $error("processed request produced no result");

    a_idle_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_res.busy) |-> r_res.bus_release)
        else $error("bus driven low while idle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_fire) |=> (r_in_vld && $stable(r_action) && $stable(r_bus_level)))
        else $error("pending request lost or overwritten");

endmodule

@@ verif/owtr_checker.sv @@
// Checker for the one-wire temperature reader: predicts every tick result and compares it.
module owtr_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_action,
    input  logic                           i_bus_level,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_bus_release,
    input  logic                           i_busy_res,
    input  logic                           i_done_res,
    input  logic [owtr_pkg::TEMP_W-1:0]    i_temperature,
    input  logic                           i_cfg_we,
    input  logic [owtr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [owtr_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_requests,
    output int                             o_reads_done
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [4:0] {
        SEQ_IDLE,
        SEQ_PRE,
        SEQ_RST_LOW,
        SEQ_RST_REL,
        SEQ_WR_LOW,
        SEQ_WR_DATA,
        SEQ_WR_REC,
        SEQ_CONV_WAIT,
        SEQ_RD_LOW,
        SEQ_RD_REL,
        SEQ_RD_SAMP,
        SEQ_RD_REC
    } t_seq;

    localparam logic [3:0] STEP_RESET1       = 4'd0;
    localparam logic [3:0] STEP_SKIP1        = 4'd1;
    localparam logic [3:0] STEP_CONVERT      = 4'd2;
    localparam logic [3:0] STEP_CONV_WAIT    = 4'd3;
    localparam logic [3:0] STEP_RESET2       = 4'd4;
    localparam logic [3:0] STEP_SKIP2        = 4'd5;
    localparam logic [3:0] STEP_READ_SCRATCH = 4'd6;
    localparam logic [3:0] STEP_READ_LOW     = 4'd7;
    localparam logic [3:0] STEP_READ_HIGH    = 4'd8;

    localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
    localparam logic [7:0] CMD_CONVERT      = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    owtr_pkg::t_cfg timing;
    t_seq           seq_phase;
    logic [15:0]    ticks_left;
    logic [7:0]     shreg;
    logic [3:0]     bits_done;
    logic [3:0]     step;
    logic [7:0]     low_byte_q;
    logic [7:0]     last_temp;
    owtr_pkg::t_res tick_results_q[$];

    function automatic logic [15:0] interval_len(t_seq p);
        case (p)
            SEQ_PRE:       return timing.pre_reset;
            SEQ_RST_LOW:   return timing.reset_low;
            SEQ_RST_REL:   return timing.reset_release;
            SEQ_WR_DATA:   return timing.write_slot;
            SEQ_RD_REC:    return timing.read_slot;
            SEQ_CONV_WAIT: return timing.convert_wait;
            SEQ_IDLE:      return 16'd0;
            default:       return 16'd1;
        endcase
    endfunction

    function automatic t_seq begin_step();
        bits_done = 4'd0;
        case (step)
            STEP_RESET1, STEP_RESET2: return SEQ_PRE;
            STEP_SKIP1, STEP_SKIP2: begin
                shreg = CMD_SKIP_ROM;
                return SEQ_WR_LOW;
            end
            STEP_CONVERT: begin
                shreg = CMD_CONVERT;
                return SEQ_WR_LOW;
            end
            STEP_READ_SCRATCH: begin
                shreg = CMD_READ_SCRATCH;
                return SEQ_WR_LOW;
            end
            STEP_CONV_WAIT: return SEQ_CONV_WAIT;
            STEP_READ_LOW, STEP_READ_HIGH: begin
                shreg = 8'd0;
                return SEQ_RD_LOW;
            end
            default: begin
                step = STEP_RESET1;
                return SEQ_IDLE;
            end
        endcase
    endfunction

    function automatic t_seq advance(t_seq p);
        case (p)
            SEQ_PRE:     return SEQ_RST_LOW;
            SEQ_RST_LOW: return SEQ_RST_REL;
            SEQ_RST_REL: begin
                step = step + 4'd1;
                return begin_step();
            end
            SEQ_WR_LOW:  return SEQ_WR_DATA;
            SEQ_WR_DATA: return SEQ_WR_REC;
            SEQ_WR_REC: begin
                shreg = shreg >> 1;
                bits_done = bits_done + 4'd1;
                if (bits_done < 4'd8) return SEQ_WR_LOW;
                step = step + 4'd1;
                return begin_step();
            end
            SEQ_CONV_WAIT: begin
                step = STEP_RESET2;
                return begin_step();
            end
            SEQ_RD_LOW:  return SEQ_RD_REL;
            SEQ_RD_REL:  return SEQ_RD_SAMP;
            SEQ_RD_SAMP: return SEQ_RD_REC;
            SEQ_RD_REC: begin
                bits_done = bits_done + 4'd1;
                if (bits_done < 4'd8) return SEQ_RD_LOW;
                if (step == STEP_READ_LOW) begin
                    low_byte_q = shreg;
                    step = STEP_READ_HIGH;
                    return begin_step();
                end
                last_temp = {shreg[3:0], low_byte_q[7:4]};
                step = STEP_RESET1;
                bits_done = 4'd0;
                return SEQ_IDLE;
            end
            default: return SEQ_IDLE;
        endcase
    endfunction

    // skip intervals of zero length
    function automatic void settle(t_seq p);
        while (p != SEQ_IDLE && interval_len(p) == 16'd0)
            p = advance(p);
        seq_phase = p;
        ticks_left = interval_len(p);
    endfunction

    function automatic owtr_pkg::t_res predict_tick(logic start, logic level);
        owtr_pkg::t_res r;
        r = '0;
        r.bus_release = 1'b1;
        if (start) begin
            step = STEP_RESET1;
            bits_done = 4'd0;
            shreg = 8'd0;
            settle(begin_step());
        end
        if (seq_phase != SEQ_IDLE) begin
            r.busy = 1'b1;
            if (seq_phase == SEQ_RST_LOW || seq_phase == SEQ_WR_LOW || seq_phase == SEQ_RD_LOW)
                r.bus_release = 1'b0;
            else if (seq_phase == SEQ_WR_DATA)
                r.bus_release = shreg[0];
            if (seq_phase == SEQ_RD_SAMP)
                shreg = {level, shreg[7:1]};
            if (ticks_left != 16'd0)
                ticks_left = ticks_left - 16'd1;
            if (ticks_left == 16'd0) begin
                settle(advance(seq_phase));
                if (seq_phase == SEQ_IDLE)
                    r.done = 1'b1;
            end
        end
        r.temperature = last_temp;
        return r;
    endfunction

    function automatic int field_errors(string label, int want, int got);
        if (want == got) return 0;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin : check_proc
        owtr_pkg::t_res want;
        owtr_pkg::t_res got;
        if (!i_rst_n) begin
            timing = '{owtr_pkg::RST_PRE_RESET, owtr_pkg::RST_RESET_LOW,
                       owtr_pkg::RST_RESET_RELEASE, owtr_pkg::RST_WRITE_SLOT,
                       owtr_pkg::RST_READ_SLOT, owtr_pkg::RST_CONVERT_WAIT};
            seq_phase = SEQ_IDLE;
            ticks_left = '0;
            shreg = '0;
            bits_done = '0;
            step = STEP_RESET1;
            low_byte_q = '0;
            last_temp = '0;
            tick_results_q.delete();
            o_fail_count = 0;
            o_requests = 0;
            o_reads_done = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    owtr_pkg::CFG_PRE_RESET:     timing.pre_reset = i_cfg_data;
                    owtr_pkg::CFG_RESET_LOW:     timing.reset_low = i_cfg_data;
                    owtr_pkg::CFG_RESET_RELEASE: timing.reset_release = i_cfg_data;
                    owtr_pkg::CFG_WRITE_SLOT:    timing.write_slot = i_cfg_data;
                    owtr_pkg::CFG_READ_SLOT:     timing.read_slot = i_cfg_data;
                    owtr_pkg::CFG_CONVERT_WAIT:  timing.convert_wait = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got.bus_release = i_bus_release;
                got.busy = i_busy_res;
                got.done = i_done_res;
                got.temperature = i_temperature;
                if (tick_results_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result with no request pending: expected none, actual %h",
                             $time, got);
                end else begin
                    want = tick_results_q.pop_front();
                    o_fail_count += field_errors("bus_release", want.bus_release, got.bus_release)
                                  + field_errors("busy_res", want.busy, got.busy)
                                  + field_errors("done_res", want.done, got.done)
                                  + field_errors("temperature", want.temperature,
                                                 got.temperature);
                    if (want.done) o_reads_done++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                tick_results_q.push_back(predict_tick(i_action, i_bus_level));
                o_requests++;
            end
        end
        o_pending = tick_results_q.size();
    end

endmodule

@@ verif/tb_one_wire_temperature_reader.sv @@
// Testbench top for the one-wire temperature reader: stimulus, timing setups and verdict.
module tb_one_wire_temperature_reader;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [owtr_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [owtr_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int LEVEL_LOW    = 0;
    localparam int LEVEL_HIGH   = 1;
    localparam int LEVEL_RANDOM = 2;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           action = 1'b0;
    logic                           bus_level = 1'b0;
    logic                           out_stall = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [owtr_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [owtr_pkg::CFG_W-1:0]     cfg_data = '0;
    bit                             calm = 1'b0;

    logic                           in_stall;
    logic                           out_valid;
    logic                           bus_release;
    logic                           busy_res;
    logic                           done_res;
    logic [owtr_pkg::TEMP_W-1:0]    temperature;

    int                             fail_count;
    int                             pending;
    int                             requests;
    int                             reads_done;
    int                             setups = 0;
    owtr_pkg::t_cfg                 timing_now;

    one_wire_temperature_reader DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_action      (action),
        .i_bus_level   (bus_level),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_bus_release (bus_release),
        .o_busy_res    (busy_res),
        .o_done_res    (done_res),
        .o_temperature (temperature),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    owtr_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_action      (action),
        .i_bus_level   (bus_level),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_bus_release (bus_release),
        .i_busy_res    (busy_res),
        .i_done_res    (done_res),
        .i_temperature (temperature),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_requests    (requests),
        .o_reads_done  (reads_done)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(0, 99) < 30);
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic pick_level(int mode);
        if (mode == LEVEL_LOW) return 1'b0;
        if (mode == LEVEL_HIGH) return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic int read_ticks(owtr_pkg::t_cfg c);
        return 2 * (c.pre_reset + c.reset_low + c.reset_release) + 32 * (2 + c.write_slot)
             + c.convert_wait + 16 * (3 + c.read_slot);
    endfunction

    task automatic send_tick(input logic act, input logic lvl);
        while (!calm && $urandom_range(0, 99) < 30) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        bus_level <= lvl;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // hold requests until every result is back, then let the sequencer settle
    task automatic wait_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input logic [owtr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [owtr_pkg::CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic set_timing(input owtr_pkg::t_cfg c);
        wait_results();
        put_reg(CFG_SPARE_LO, 16'($urandom_range(0, 65535)));
        put_reg(CFG_SPARE_HI, 16'hFFFF);
        put_reg(owtr_pkg::CFG_PRE_RESET, c.pre_reset);
        put_reg(owtr_pkg::CFG_RESET_LOW, c.reset_low);
        put_reg(owtr_pkg::CFG_RESET_RELEASE, c.reset_release);
        put_reg(owtr_pkg::CFG_WRITE_SLOT, c.write_slot);
        put_reg(owtr_pkg::CFG_READ_SLOT, c.read_slot);
        put_reg(owtr_pkg::CFG_CONVERT_WAIT, c.convert_wait);
        cfg_we <= 1'b0;
        @(posedge clk);
        timing_now = c;
        setups++;
    endtask

    task automatic run_read(input int level_mode);
        int span;
        span = read_ticks(timing_now) + $urandom_range(2, 8);
        send_tick(1'b1, pick_level(level_mode));
        repeat (span) send_tick(1'b0, pick_level(level_mode));
    endtask

    task automatic run_noise(input int ticks, input int restart_pct);
        repeat (ticks) send_tick($urandom_range(0, 99) < restart_pct, pick_level(LEVEL_RANDOM));
    endtask

    initial begin
        owtr_pkg::t_cfg c;
        timing_now = '{owtr_pkg::RST_PRE_RESET, owtr_pkg::RST_RESET_LOW,
                       owtr_pkg::RST_RESET_RELEASE, owtr_pkg::RST_WRITE_SLOT,
                       owtr_pkg::RST_READ_SLOT, owtr_pkg::RST_CONVERT_WAIT};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle ticks, start, restart while busy, back-to-back starts
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        repeat (6) send_tick(1'b0, pick_level(LEVEL_RANDOM));
        send_tick(1'b1, 1'b1);
        repeat (8) send_tick(1'b0, pick_level(LEVEL_RANDOM));
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);

        // zero-length intervals everywhere, no idling on either side
        calm <= 1'b1;
        set_timing('0);
        run_read(LEVEL_RANDOM);
        run_read(LEVEL_HIGH);
        calm <= 1'b0;

        set_timing('{default: 16'd1});
        run_read(LEVEL_LOW);
        wait_results();
        run_read(LEVEL_HIGH);
        run_read(LEVEL_RANDOM);

        c.pre_reset = 16'($urandom_range(0, 4));
        c.reset_low = 16'($urandom_range(0, 4));
        c.reset_release = 16'($urandom_range(0, 4));
        c.write_slot = 16'($urandom_range(0, 4));
        c.read_slot = 16'($urandom_range(0, 4));
        c.convert_wait = 16'($urandom_range(0, 4));
        set_timing(c);
        run_read(LEVEL_RANDOM);
        run_noise(40, 3);
        run_read(LEVEL_RANDOM);

        set_timing('{default: 16'hFFFF});
        run_noise(100, 2);

        wait_results();
        $display("Run sent %0d bus ticks over %0d timing setups;", requests, setups);
        $display("%0d temperature reads ran to completion and were checked.", reads_done);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
